[hw/rtl/pgca_pkg.sv]
// ----------------------------------------------------------------------------
// pgca_pkg
// Types and fixed constants shared by the projected grid cell address block.
// ----------------------------------------------------------------------------
`default_nettype none

package pgca_pkg;

   // field widths fixed by the transaction format
   localparam int COEF_W     = 16;
   localparam int POINT_W    = 24;
   localparam int PROD_W     = COEF_W + POINT_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int COEF_SHIFT = 14;
   localparam int COORD_W    = 26;
   localparam int SHIFT_W    = COORD_W + 1;
   localparam int FOLD_W     = COORD_W + 1;
   localparam int SQ_W       = 52;
   localparam int ADDR_W     = 32;
   localparam int FRAC_OUT_W = 12;

   // saturation bounds of a Q13.12 coordinate
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 52;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQ_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_STRIDE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ORIGIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SENTINEL_SUB    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SENTINEL_ADD    = 3'd5;

   typedef struct packed {
      logic signed [COEF_W-1:0]  coef_x_a;
      logic signed [COEF_W-1:0]  coef_x_b;
      logic signed [COEF_W-1:0]  coef_y_a;
      logic signed [COEF_W-1:0]  coef_y_b;
      logic signed [COEF_W-1:0]  coef_z_a;
      logic signed [COEF_W-1:0]  coef_z_b;
      logic signed [POINT_W-1:0] point_x;
      logic signed [POINT_W-1:0] point_y;
   } pgca_req_type;

   typedef struct packed {
      logic signed [ADDR_W-1:0]  cell_address;
      logic [FRAC_OUT_W-1:0]     frac_x;
      logic [FRAC_OUT_W-1:0]     frac_y;
      logic [FRAC_OUT_W-1:0]     frac_z;
      logic                      folded;
      logic                      inside_res;
   } pgca_rsp_type;

   // settings the datapath sees
   typedef struct packed {
      logic [SQ_W-1:0]   radius_sq_limit;
      logic [23:0]       plane_stride;
      logic [15:0]       row_stride;
      logic [ADDR_W-1:0] addr_offset;
      logic [ADDR_W-1:0] sentinel_add;
   } pgca_cfg_type;

endpackage

`default_nettype wire

[hw/rtl/pgca_if.sv]
// ----------------------------------------------------------------------------
// pgca channel interfaces
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgca_req_if;
   import pgca_pkg::*;
   logic         valid;
   logic         ready;
   pgca_req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pgca_rsp_if;
   import pgca_pkg::*;
   logic         valid;
   logic         ready;
   pgca_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pgca_pipe.sv]
// ----------------------------------------------------------------------------
// pgca_pipe
// Four-stage datapath: products, axis sums with saturation, squares and fold,
// radius test and stride products; the address sum follows the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pgca_pipe #(
   parameter int FRAC_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  pgca_pkg::pgca_req_type in_data,
   input  pgca_pkg::pgca_cfg_type cfg,
   output logic                   res_vld,
   output pgca_pkg::pgca_rsp_type res
);
   import pgca_pkg::*;

   localparam int FLW  = FOLD_W - FRAC_BITS;
   localparam int PZ_W = FLW + 25;
   localparam int PY_W = FLW + 17;

   logic signed [COEF_W-1:0]  coef_a [3];
   logic signed [COEF_W-1:0]  coef_b [3];

   // stage 1 registers
   logic                      vld1_ff;
   logic signed [PROD_W-1:0]  pa_ff [3];
   logic signed [PROD_W-1:0]  pa_in [3];
   logic signed [PROD_W-1:0]  pb_ff [3];
   logic signed [PROD_W-1:0]  pb_in [3];

   // stage 2 registers
   logic                      vld2_ff;
   logic signed [SUM_W-1:0]   sum_w [3];
   logic signed [SHIFT_W-1:0] sh_w [3];
   logic signed [COORD_W-1:0] coord_ff [3];
   logic signed [COORD_W-1:0] coord_in [3];

   // stage 3 registers
   logic                      vld3_ff;
   logic [COORD_W-1:0]        mag_w [3];
   logic signed [FOLD_W-1:0]  fold_w [3];
   logic [SQ_W-1:0]           sq_ff [3];
   logic [SQ_W-1:0]           sq_in [3];
   logic signed [FLW-1:0]     fl_ff [3];
   logic signed [FLW-1:0]     fl_in [3];
   logic [FRAC_BITS-1:0]      fr3_ff [3];
   logic [FRAC_BITS-1:0]      fr3_in [3];
   logic                      neg3_ff;
   logic                      neg3_in;

   // stage 4 registers
   logic                      vld4_ff;
   logic [SQ_W-1:0]           r2_w;
   logic signed [PZ_W-1:0]    pz_w;
   logic signed [PY_W-1:0]    py_w;
   logic [ADDR_W-1:0]         pz4_ff;
   logic [ADDR_W-1:0]         pz4_in;
   logic [ADDR_W-1:0]         py4_ff;
   logic [ADDR_W-1:0]         py4_in;
   logic [ADDR_W-1:0]         fx4_ff;
   logic [ADDR_W-1:0]         fx4_in;
   logic [FRAC_BITS-1:0]      fr4_ff [3];
   logic                      neg4_ff;
   logic                      inside4_ff;
   logic                      inside4_in;

   logic [ADDR_W-1:0]         addr_w;

   assign coef_a[0] = in_data.coef_x_a;
   assign coef_b[0] = in_data.coef_x_b;
   assign coef_a[1] = in_data.coef_y_a;
   assign coef_b[1] = in_data.coef_y_b;
   assign coef_a[2] = in_data.coef_z_a;
   assign coef_b[2] = in_data.coef_z_b;

   // stage 1: six coefficient products
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         pa_in[d] = coef_a[d] * in_data.point_x;
         pb_in[d] = coef_b[d] * in_data.point_y;
      end
   end

   // stage 2: axis sum, floor shift to Q13.12, saturate
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         sum_w[d] = SUM_W'(pa_ff[d]) + SUM_W'(pb_ff[d]);
         sh_w[d]  = SHIFT_W'(sum_w[d] >>> COEF_SHIFT);
         if (sh_w[d][SHIFT_W-1] != sh_w[d][SHIFT_W-2]) begin
            coord_in[d] = sh_w[d][SHIFT_W-1] ? COORD_MIN : COORD_MAX;
         end else begin
            coord_in[d] = sh_w[d][COORD_W-1:0];
         end
      end
   end

   // stage 3: squared magnitudes, fold by x sign, floor and fraction
   assign neg3_in = coord_ff[0][COORD_W-1];

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         mag_w[d]  = coord_ff[d][COORD_W-1] ? COORD_W'(-coord_ff[d]) : COORD_W'(coord_ff[d]);
         sq_in[d]  = SQ_W'(mag_w[d]) * SQ_W'(mag_w[d]);
         fold_w[d] = neg3_in ? -FOLD_W'(coord_ff[d]) : FOLD_W'(coord_ff[d]);
         fl_in[d]  = FLW'(fold_w[d] >>> FRAC_BITS);
         fr3_in[d] = fold_w[d][FRAC_BITS-1:0];
      end
   end

   // stage 4: radius test and stride products
   assign r2_w       = sq_ff[0] + sq_ff[1] + sq_ff[2];
   assign inside4_in = r2_w < cfg.radius_sq_limit;
   assign pz_w       = fl_ff[2] * $signed({1'b0, cfg.plane_stride});
   assign py_w       = fl_ff[1] * $signed({1'b0, cfg.row_stride});
   assign pz4_in     = ADDR_W'(pz_w);
   assign py4_in     = ADDR_W'(py_w);
   assign fx4_in     = ADDR_W'(fl_ff[0]);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff      <= pa_in;
         pb_ff      <= pb_in;
         coord_ff   <= coord_in;
         sq_ff      <= sq_in;
         fl_ff      <= fl_in;
         fr3_ff     <= fr3_in;
         neg3_ff    <= neg3_in;
         pz4_ff     <= pz4_in;
         py4_ff     <= py4_in;
         fx4_ff     <= fx4_in;
         fr4_ff     <= fr3_ff;
         neg4_ff    <= neg3_ff;
         inside4_ff <= inside4_in;
      end
   end

   // final address sum, sentinel when outside
   assign addr_w  = pz4_ff + py4_ff + fx4_ff + cfg.addr_offset;
   assign res_vld = vld4_ff;

   always_comb begin
      res.cell_address = inside4_ff ? addr_w : cfg.sentinel_add;
      res.frac_x       = FRAC_OUT_W'(fr4_ff[0]);
      res.frac_y       = FRAC_OUT_W'(fr4_ff[1]);
      res.frac_z       = FRAC_OUT_W'(fr4_ff[2]);
      res.folded       = neg4_ff;
      res.inside_res   = inside4_ff;
   end

endmodule

`default_nettype wire

[hw/rtl/projected_grid_cell_address.sv]
// ----------------------------------------------------------------------------
// projected_grid_cell_address
// Projects a 2-D point into a 3-D grid and returns the base cell address,
// the in-cell fractions, the fold flag and the radius mask.
//
//   channel   direction  handshake            payload
//   req_chan  in         valid / ready        six coefficients, point
//   rsp_chan  out        valid / ready        address, fractions, flags
//   csr_*     in         csr_wr_en            csr_index, csr_wr_data
//
// One transaction per cycle while the skid register is empty; a result passes
// through four datapath register stages and the output register.
// Reset clears all valid bits and the settings registers.
// A stalled response fills a one-entry skid register; req_chan.ready then
// drops, the datapath holds, and it resumes as soon as the skid empties.
// ----------------------------------------------------------------------------
`default_nettype none

module projected_grid_cell_address #(
   parameter int FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   pgca_req_if.sink                            req_chan,
   pgca_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [pgca_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pgca_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import pgca_pkg::*;

   logic [SQ_W-1:0]   radius_sq_limit_ff;
   logic [23:0]       plane_stride_ff;
   logic [15:0]       row_stride_ff;
   logic [ADDR_W-1:0] grid_origin_ff;
   logic [ADDR_W-1:0] sentinel_sub_ff;
   logic [ADDR_W-1:0] sentinel_add_ff;
   logic [ADDR_W-1:0] addr_offset_ff;
   logic [ADDR_W-1:0] addr_offset_in;

   pgca_cfg_type cfg;
   logic         en;
   logic         res_vld;
   pgca_rsp_type res;
   logic         handoff;

   logic         out_vld_ff;
   logic         out_vld_in;
   pgca_rsp_type out_data_ff;
   pgca_rsp_type out_data_in;
   logic         skid_vld_ff;
   logic         skid_vld_in;
   pgca_rsp_type skid_data_ff;
   pgca_rsp_type skid_data_in;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_limit_ff <= '0;
         plane_stride_ff    <= '0;
         row_stride_ff      <= '0;
         grid_origin_ff     <= '0;
         sentinel_sub_ff    <= '0;
         sentinel_add_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RADIUS_SQ_LIMIT: radius_sq_limit_ff <= csr_wr_data[SQ_W-1:0];
            CSR_PLANE_STRIDE:    plane_stride_ff    <= csr_wr_data[23:0];
            CSR_ROW_STRIDE:      row_stride_ff      <= csr_wr_data[15:0];
            CSR_GRID_ORIGIN:     grid_origin_ff     <= csr_wr_data[ADDR_W-1:0];
            CSR_SENTINEL_SUB:    sentinel_sub_ff    <= csr_wr_data[ADDR_W-1:0];
            CSR_SENTINEL_ADD:    sentinel_add_ff    <= csr_wr_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // constant part of the address, folded once
   assign addr_offset_in = grid_origin_ff - sentinel_sub_ff + sentinel_add_ff;

   always_ff @(posedge clock) begin
      addr_offset_ff <= addr_offset_in;
   end

   always_comb begin
      cfg.radius_sq_limit = radius_sq_limit_ff;
      cfg.plane_stride    = plane_stride_ff;
      cfg.row_stride      = row_stride_ff;
      cfg.addr_offset     = addr_offset_ff;
      cfg.sentinel_add    = sentinel_add_ff;
   end

   // datapath advances while the skid register is free
   assign en             = !skid_vld_ff;
   assign req_chan.ready = !skid_vld_ff && !reset;
   assign handoff        = en && res_vld;

   pgca_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pipe (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_chan.valid && req_chan.ready),
      .in_data (req_chan.data),
      .cfg     (cfg),
      .res_vld (res_vld),
      .res     (res)
   );

   // output register with skid entry
   always_comb begin
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (!out_vld_ff || rsp_chan.ready) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = handoff;
            out_data_in = res;
         end
      end else if (handoff) begin
         skid_vld_in  = 1'b1;
         skid_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.data  = out_data_ff;

endmodule

`default_nettype wire

[hw/rtl/pgca_checker.sv]
// ----------------------------------------------------------------------------
// pgca_checker
// Port-level checks on the request and response channels, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pgca_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input pgca_pkg::pgca_rsp_type rsp_data
);
   import pgca_pkg::*;

   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // request backpressure only follows a stalled response
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) && !$past(reset) |-> $past(rsp_valid && !rsp_ready))
      else $error("request stalled without response backpressure");

   // no response sooner than the pipeline depth after reset
   assert property (@(posedge clock)
      rsp_valid |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)
                    && !$past(reset, 4))
      else $error("response too soon after reset");

endmodule

bind projected_grid_cell_address pgca_checker u_pgca_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

`default_nettype wire

[tb/projected_grid_cell_address_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// projected_grid_cell_address_tb
// Self-checking bench for the projected grid cell address block. A driver
// feeds request transactions from a queue, and a monitor predicts every
// response from the register settings and compares it field by field. The run
// covers directed corner points, saturation and fold cases, and random traffic
// under several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------

module projected_grid_cell_address_tb;
   import pgca_pkg::*;

   localparam int FRAC_BITS      = 12;
   localparam int CLK_HALF       = 4;
   localparam int RESET_CYCLES   = 12;
   localparam int PIPE_LATENCY   = 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 180;
   localparam int RESET_ITEMS    = 40;
   localparam int PAUSE_PHASE    = 5;

   // index with no register behind it, writes must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd6;

   typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_type;

   // local copy of the register file
   typedef struct packed {
      logic [SQ_W-1:0]   bound_sq;
      logic [23:0]       plane_step;
      logic [15:0]       row_step;
      logic [ADDR_W-1:0] origin;
      logic [ADDR_W-1:0] sent_sub;
      logic [ADDR_W-1:0] sent_add;
   } grid_setting_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   pgca_req_if req_chan ();
   pgca_rsp_if rsp_chan ();

   projected_grid_cell_address #(
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   pgca_req_type     pending_reqs[$];
   pgca_rsp_type     expected_cells[$];
   grid_setting_type active_setting;
   int               sender_idle_pct;
   int               receiver_stall_pct;
   bit               req_fired;
   int               sent_count;
   int               checked_count;
   int               mismatch_count;
   int               setting_count;
   int               folded_count;
   int               outside_count;
   int               quiet_cycles;

   // clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // one projected axis: floor of the weighted sum in Q13.12, saturated
   function automatic longint axis_coord(logic signed [COEF_W-1:0] wa,
                                         logic signed [COEF_W-1:0] wb,
                                         logic signed [POINT_W-1:0] px,
                                         logic signed [POINT_W-1:0] py);
      longint acc;
      acc = longint'(wa) * longint'(px) + longint'(wb) * longint'(py);
      acc = acc >>> COEF_SHIFT;
      if (acc > longint'(COORD_MAX)) acc = longint'(COORD_MAX);
      if (acc < longint'(COORD_MIN)) acc = longint'(COORD_MIN);
      return acc;
   endfunction

   function automatic pgca_rsp_type predict_cell(pgca_req_type req, grid_setting_type s);
      longint       ax [3];
      longint       cell_idx [3];
      longint       v;
      longint       r2;
      logic         flip;
      logic         in_radius;
      logic [31:0]  addr;
      pgca_rsp_type rsp;
      ax[0] = axis_coord(req.coef_x_a, req.coef_x_b, req.point_x, req.point_y);
      ax[1] = axis_coord(req.coef_y_a, req.coef_y_b, req.point_x, req.point_y);
      ax[2] = axis_coord(req.coef_z_a, req.coef_z_b, req.point_x, req.point_y);
      r2 = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
      in_radius = r2 < longint'({12'd0, s.bound_sq});
      // fold on the sign of x, zero counts as positive
      flip = ax[0] < 0;
      rsp = '0;
      for (int d = 0; d < 3; d++) begin
         v = flip ? -ax[d] : ax[d];
         cell_idx[d] = v >>> FRAC_BITS;
         case (d)
            0: rsp.frac_x = 12'(v & ((longint'(1) << FRAC_BITS) - 1));
            1: rsp.frac_y = 12'(v & ((longint'(1) << FRAC_BITS) - 1));
            default: rsp.frac_z = 12'(v & ((longint'(1) << FRAC_BITS) - 1));
         endcase
      end
      // all address arithmetic wraps at 32 bits
      addr = 32'(cell_idx[2]) * {8'd0, s.plane_step}
           + 32'(cell_idx[1]) * {16'd0, s.row_step}
           + 32'(cell_idx[0]) + s.origin - s.sent_sub + s.sent_add;
      rsp.cell_address = in_radius ? addr : s.sent_add;
      rsp.folded = flip;
      rsp.inside_res = in_radius;
      return rsp;
   endfunction

   task automatic check_cell(pgca_rsp_type want, pgca_rsp_type got);
      checked_count++;
      if (got.cell_address !== want.cell_address || got.frac_x !== want.frac_x ||
          got.frac_y !== want.frac_y || got.frac_z !== want.frac_z ||
          got.folded !== want.folded || got.inside_res !== want.inside_res) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at result %0d", checked_count);
            $display("  expected addr %h frac %h %h %h fold %b in %b",
                     want.cell_address, want.frac_x, want.frac_y,
                     want.frac_z, want.folded, want.inside_res);
            $display("  got      addr %h frac %h %h %h fold %b in %b",
                     got.cell_address, got.frac_x, got.frac_y,
                     got.frac_z, got.folded, got.inside_res);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic pgca_req_type make_req(int cxa, int cxb, int cya, int cyb,
                                             int cza, int czb, int px, int py);
      pgca_req_type r;
      r.coef_x_a = 16'(cxa);
      r.coef_x_b = 16'(cxb);
      r.coef_y_a = 16'(cya);
      r.coef_y_b = 16'(cyb);
      r.coef_z_a = 16'(cza);
      r.coef_z_b = 16'(czb);
      r.point_x  = 24'(px);
      r.point_y  = 24'(py);
      return r;
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      logic [COEF_W-1:0] corner [6] = '{16'h8000, 16'h7fff, 16'h0000,
                                        16'hffff, 16'h0001, 16'h4000};
      case ($urandom_range(9))
         0:          return corner[$urandom_range(5)];
         1, 2, 3, 4: return 16'($urandom);
         default:    return 16'(int'($urandom_range(8192)) - 4096);
      endcase
   endfunction

   function automatic logic [POINT_W-1:0] pick_point();
      logic [POINT_W-1:0] corner [7] = '{24'h800000, 24'h7fffff, 24'h000000, 24'hffffff,
                                         24'h000001, 24'h001000, 24'hfff000};
      case ($urandom_range(9))
         0:       return corner[$urandom_range(6)];
         1, 2, 3: return 24'($urandom);
         default: return 24'(int'($urandom_range(65536)) - 32768);
      endcase
   endfunction

   function automatic pgca_req_type random_req();
      pgca_req_type r;
      r.coef_x_a = pick_coef();
      r.coef_x_b = pick_coef();
      r.coef_y_a = pick_coef();
      r.coef_y_b = pick_coef();
      r.coef_z_a = pick_coef();
      r.coef_z_b = pick_coef();
      r.point_x  = pick_point();
      r.point_y  = pick_point();
      return r;
   endfunction

   // extremes on two variants, random settings otherwise
   function automatic grid_setting_type random_setting(int variant);
      grid_setting_type s;
      s.bound_sq   = 52'({$urandom, $urandom}) >> $urandom_range(SQ_W - 1);
      s.plane_step = 24'($urandom) >> $urandom_range(23);
      s.row_step   = 16'($urandom) >> $urandom_range(15);
      s.origin     = $urandom;
      s.sent_sub   = $urandom;
      s.sent_add   = $urandom;
      if (variant == 0) begin
         s.bound_sq   = '1;
         s.plane_step = '1;
         s.row_step   = '1;
         s.origin     = 32'h7fff_ffff;
         s.sent_sub   = 32'h8000_0000;
      end else if (variant == 3) begin
         s.bound_sq   = '0;
         s.plane_step = '0;
         s.row_step   = '0;
         s.origin     = 32'h8000_0000;
         s.sent_sub   = 32'h7fff_ffff;
         s.sent_add   = '0;
      end
      return s;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // unused upper data bits carry noise, narrow registers must drop it
   task automatic apply_setting(grid_setting_type s);
      write_reg(CSR_RADIUS_SQ_LIMIT, s.bound_sq);
      write_reg(CSR_PLANE_STRIDE, {28'($urandom), s.plane_step});
      write_reg(CSR_ROW_STRIDE, {36'({$urandom, $urandom}), s.row_step});
      write_reg(CSR_GRID_ORIGIN, {20'($urandom), s.origin});
      write_reg(CSR_SENTINEL_SUB, {20'($urandom), s.sent_sub});
      write_reg(CSR_SENTINEL_ADD, {20'($urandom), s.sent_add});
      write_reg(CSR_SPARE_IDX, 52'({$urandom, $urandom}));
      active_setting = s;
      setting_count++;
      @(posedge clock);
   endtask

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
         default:       begin sender_idle_pct = 21; receiver_stall_pct = 21; end
      endcase
   endtask

   // block until every queued transaction has come back, then let the pipe settle
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_reqs.size() != 0 || req_chan.valid || expected_cells.size() != 0);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // driver: request valid and response ready change on the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      logic         next_valid;
      pgca_req_type next_data;
      next_valid = req_chan.valid;
      next_data  = req_chan.data;
      if (req_fired) next_valid = 1'b0;
      req_fired = 1'b0;
      if (!reset && !next_valid && pending_reqs.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
         next_data  = pending_reqs.pop_front();
         next_valid = 1'b1;
      end
      req_chan.valid <= next_valid;
      req_chan.data  <= next_data;
      rsp_chan.ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // ------------------------------------------------------------------------
   // monitor: accepted requests become expectations, responses are checked
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      pgca_rsp_type want;
      logic         moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            want = predict_cell(req_chan.data, active_setting);
            expected_cells.push_back(want);
            if (want.folded) folded_count++;
            if (!want.inside_res) outside_count++;
            req_fired = 1'b1;
            sent_count++;
            moved = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            if (expected_cells.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result: addr %h frac %h %h %h fold %b in %b",
                           rsp_chan.data.cell_address, rsp_chan.data.frac_x,
                           rsp_chan.data.frac_y, rsp_chan.data.frac_z,
                           rsp_chan.data.folded, rsp_chan.data.inside_res);
            end else begin
               want = expected_cells.pop_front();
               check_cell(want, rsp_chan.data);
            end
         end
      end
      // watchdog on stretches with no transaction at all
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_cells.size());
         $display("projected_grid_cell_address_tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      grid_setting_type s;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      req_chan.valid     = 1'b0;
      req_chan.data      = '0;
      rsp_chan.ready     = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      active_setting     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: zero bound puts every point outside, address reads zero
      for (int i = 0; i < RESET_ITEMS; i++) pending_reqs.push_back(random_req());
      wait_drained();

      // directed corners under a unit radius bound and maximal strides
      s.bound_sq   = 52'd1 << 24;
      s.plane_step = '1;
      s.row_step   = '1;
      s.origin     = 32'h7fff_ffff;
      s.sent_sub   = 32'h8000_0000;
      s.sent_add   = $urandom;
      apply_setting(s);
      pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0));
      // just inside and exactly on the radius bound
      pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 0, 4095, 0));
      pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 0, 4096, 0));
      pending_reqs.push_back(make_req(16384, 0, 16384, 0, 16384, 0, 2364, 0));
      // negative x folds all three axes
      pending_reqs.push_back(make_req(-16384, 0, 0, 0, 0, 0, 4095, 0));
      pending_reqs.push_back(make_req(-1, 0, -1, 0, -1, 0, 1, 0));
      pending_reqs.push_back(make_req(-1, 0, 0, 0, 0, 0, 1, 0));
      pending_reqs.push_back(make_req(16384, 0, 0, 16384, 0, 0, -4096, 4095));
      // zero x axis stays unfolded, negative cells wrap the address
      pending_reqs.push_back(make_req(0, 0, 16384, 0, 0, -16384, 2000, 1000));
      pending_reqs.push_back(make_req(0, 0, -16384, 0, -16384, 0, 100, 0));
      pending_reqs.push_back(make_req(8192, 8192, -8192, 8192, 8192, -8192, 3000, -1000));
      // tiny products that floor to zero, and small ones that floor to two or minus two
      pending_reqs.push_back(make_req(1, 1, 1, 1, 1, 1, 1, 1));
      pending_reqs.push_back(make_req(0, 32767, 0, -32768, 0, 32767, 0, -1));
      // coordinate saturation in both directions
      pending_reqs.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767,
                                      8388607, 8388607));
      pending_reqs.push_back(make_req(-32768, -32768, -32768, -32768, -32768, -32768,
                                      -8388608, -8388608));
      pending_reqs.push_back(make_req(-32768, -32768, -32768, -32768, -32768, -32768,
                                      8388607, 8388607));
      pending_reqs.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767,
                                      -8388608, -8388608));
      // near cancellation of extreme weights
      pending_reqs.push_back(make_req(32767, -32768, -32768, 32767, 32767, -32768,
                                      8388607, 8388607));
      pending_reqs.push_back(make_req(-1, -1, -1, -1, -1, -1, -8388608, 8388607));
      wait_drained();

      // random traffic, one register setting and idling pattern per phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_setting(random_setting(p));
         set_idle(idle_mode_type'(p % 4));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // sender holds off mid-phase until the pipe has fully drained
            if (p == PAUSE_PHASE && i == PHASE_ITEMS / 2) wait_drained();
            pending_reqs.push_back(random_req());
         end
         wait_drained();
      end
      set_idle(IDLE_NONE);
      repeat (4 * PIPE_LATENCY) @(posedge clock);

      $display("%0d requests under %0d register settings, %0d results checked",
               sent_count, setting_count, checked_count);
      $display("%0d folded, %0d outside radius, %0d mismatches, idle and stall mixes",
               folded_count, outside_count, mismatch_count);
      if (expected_cells.size() != 0)
         $display("%0d results never arrived", expected_cells.size());
      if (mismatch_count == 0 && expected_cells.size() == 0)
         $display("projected_grid_cell_address_tb passed");
      else
         $display("projected_grid_cell_address_tb failed");
      $finish;
   end

endmodule

[files.f]
hw/rtl/pgca_pkg.sv
hw/rtl/pgca_if.sv
hw/rtl/pgca_pipe.sv
hw/rtl/projected_grid_cell_address.sv
hw/rtl/pgca_checker.sv
tb/projected_grid_cell_address_tb.sv
